### rtl/bpsm_pkg.sv
// Shared types, codes and constants of the block pool stream manager.
package bpsm_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int BYTES_W    = 21;
    localparam int WORD_W     = 32;
    localparam int STAMP_W    = 64;
    localparam int ADDR_W     = 4;
    localparam int MIN_POOL   = 2;

    typedef enum logic [3:0] {
        CMD_PROD_ACQ    = 4'd0,
        CMD_PROD_COMMIT = 4'd1,
        CMD_PROD_ABORT  = 4'd2,
        CMD_CONS_ACQ    = 4'd3,
        CMD_CONS_REL    = 4'd4,
        CMD_OUT_ACQ     = 4'd5,
        CMD_OUT_COMMIT  = 4'd6,
        CMD_LATE        = 4'd7,
        CMD_CLEAR       = 4'd8,
        CMD_QUERY       = 4'd9
    } t_cmd_code;

    typedef enum logic [2:0] {
        PH_FREE   = 3'd0,
        PH_PROD   = 3'd1,
        PH_READY  = 3'd2,
        PH_PROC   = 3'd3,
        PH_OUTRDY = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_BLOCK    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_ACTIVE = 2'd0,
        REG_SIZE   = 2'd1,
        REG_DROP   = 2'd2,
        REG_BASE   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]   active_blocks;
        logic [BYTES_W-1:0] block_size_bytes;
        logic               drop_oldest;
        logic [WORD_W-1:0]  payload_base;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic scan;
        logic apply;
        logic fetch;
        logic load;
    } t_ctl;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

### rtl/bpsm_ctrl.sv
// Command sequencer: accept, scan, apply, fetch, deliver.
module bpsm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bpsm_pkg::t_sts i_sts,
    output bpsm_pkg::t_ctl o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_FETCH,
        S_DONE
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:  if (i_valid) r_state <= S_SCAN;
                S_SCAN:  if (i_sts.scan_done) r_state <= S_APPLY;
                S_APPLY: r_state <= S_FETCH;
                S_FETCH: r_state <= S_DONE;
                S_DONE:  if (i_sts.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_ctl.take  = (r_state == S_IDLE) && i_valid;
    assign o_ctl.scan  = (r_state == S_SCAN);
    assign o_ctl.apply = (r_state == S_APPLY);
    assign o_ctl.fetch = (r_state == S_FETCH);
    assign o_ctl.load  = (r_state == S_DONE) && i_sts.out_free;

endmodule

### rtl/bpsm_dpath.sv
// Descriptor store, pool scan, command update, counters and result register.
module bpsm_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bpsm_pkg::t_cfg                 i_cfg,
    input  bpsm_pkg::t_ctl                 i_ctl,
    output bpsm_pkg::t_sts                 o_sts,
    input  logic [3:0]                     i_command,
    input  logic [bpsm_pkg::IDX_W-1:0]     i_block_index,
    input  logic [bpsm_pkg::BYTES_W-1:0]   i_valid_bytes,
    input  logic                           i_stamp_present,
    input  logic [bpsm_pkg::STAMP_W-1:0]   i_stamp_in,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [1:0]                     o_status,
    output logic [bpsm_pkg::IDX_W-1:0]     o_granted_index,
    output logic [bpsm_pkg::WORD_W-1:0]    o_payload_address,
    output logic [bpsm_pkg::BYTES_W-1:0]   o_held_bytes,
    output logic [bpsm_pkg::WORD_W-1:0]    o_sequence_out,
    output logic [bpsm_pkg::STAMP_W-1:0]   o_stamp_out,
    output logic [bpsm_pkg::CNT_W-1:0]     o_ready_count,
    output logic [bpsm_pkg::WORD_W-1:0]    o_overrun_count,
    output logic [bpsm_pkg::WORD_W-1:0]    o_drop_count,
    output logic [bpsm_pkg::WORD_W-1:0]    o_corrupt_count,
    output logic [bpsm_pkg::WORD_W-1:0]    o_underrun_count,
    output logic [bpsm_pkg::WORD_W-1:0]    o_late_count
);

    localparam int N = bpsm_pkg::MAX_BLOCKS;
    localparam int IW = bpsm_pkg::IDX_W;
    localparam int CW = bpsm_pkg::CNT_W;
    localparam int BW = bpsm_pkg::BYTES_W;
    localparam int WW = bpsm_pkg::WORD_W;
    localparam int SW = bpsm_pkg::STAMP_W;
    localparam int PW = BW + IW;

    // Latched command
    logic [3:0]  r_cmd;
    logic [IW-1:0] r_idx;
    logic [BW-1:0] r_vb;
    logic        r_has_stamp;
    logic [SW-1:0] r_stamp;

    // Descriptor store
    bpsm_pkg::t_phase r_phase [N];
    logic [WW-1:0] seq_mem   [N];
    logic [BW-1:0] vb_mem    [N];
    logic [SW-1:0] stamp_mem [N];

    // Scan pipeline
    logic [CW-1:0] r_scan_i;
    logic [IW-1:0] r_ev_i;
    logic          r_ev_v;
    bpsm_pkg::t_phase r_ph_q;
    logic [WW-1:0] r_sq_q;
    logic          r_free_f;
    logic [IW-1:0] r_free_i;
    logic          r_old_f;
    logic [IW-1:0] r_old_i;
    logic [WW-1:0] r_old_seq;
    bpsm_pkg::t_phase r_idx_ph;
    logic [CW-1:0] r_rdy_cnt;
    logic [BW-1:0] r_vb_q;
    logic [SW-1:0] r_st_q;

    // Counters
    logic [WW-1:0] r_seq_ctr, r_ovr, r_drop, r_corr, r_undr, r_late;

    // Step result
    bpsm_pkg::t_status r_res_st;
    logic          r_grant;
    logic          r_cons_ok;
    logic [IW-1:0] r_res_idx;
    logic [CW-1:0] r_res_rdy;
    logic [WW-1:0] r_res_addr;
    logic [BW-1:0] r_res_held;
    logic [WW-1:0] r_res_seq;
    logic [SW-1:0] r_res_stamp;

    // Output register
    logic r_out_v;

    logic [CW-1:0] pool_n;
    logic          pool_ok;
    logic          idx_out;
    logic [PW-1:0] addr_prod;

    assign pool_n  = (i_cfg.active_blocks > CW'(N)) ? CW'(N) : i_cfg.active_blocks;
    assign pool_ok = pool_n >= CW'(bpsm_pkg::MIN_POOL);
    assign idx_out = {1'b0, r_idx} >= pool_n;
    assign addr_prod = PW'(i_cfg.block_size_bytes) * PW'(r_res_idx);

    assign o_sts.scan_done = (r_scan_i >= pool_n) && !r_ev_v;
    assign o_sts.out_free  = !r_out_v || i_out_ready;

    // Apply decode
    logic          a_ph_we;
    logic [IW-1:0] a_ph_addr;
    bpsm_pkg::t_phase a_ph_val;
    logic          a_mem_we;
    logic          a_seq_we;
    logic          a_stamp_we;
    logic [BW-1:0] a_vb_val;
    logic [SW-1:0] a_stamp_val;
    logic          a_clear;
    bpsm_pkg::t_status a_st;
    logic          a_grant, a_cons;
    logic [IW-1:0] a_gidx;
    logic [CW-1:0] a_rdy;
    logic          a_ovr, a_drop, a_corr, a_undr, a_late;
    logic [WW-1:0] a_seq_next;

    always_comb begin
        a_ph_we     = 1'b0;
        a_ph_addr   = r_idx;
        a_ph_val    = bpsm_pkg::PH_FREE;
        a_mem_we    = 1'b0;
        a_seq_we    = 1'b0;
        a_stamp_we  = 1'b0;
        a_vb_val    = '0;
        a_stamp_val = '0;
        a_clear     = 1'b0;
        a_st        = bpsm_pkg::ST_OK;
        a_grant     = 1'b0;
        a_cons      = 1'b0;
        a_gidx      = '0;
        a_rdy       = r_rdy_cnt;
        a_ovr       = 1'b0;
        a_drop      = 1'b0;
        a_corr      = 1'b0;
        a_undr      = 1'b0;
        a_late      = 1'b0;
        a_seq_next  = r_seq_ctr + WW'(1);
        priority if (r_cmd == bpsm_pkg::CMD_CLEAR) begin
            a_clear = 1'b1;
            a_rdy   = '0;
        end else if (r_cmd > bpsm_pkg::CMD_QUERY || !pool_ok) begin
            a_st = bpsm_pkg::ST_INVALID;
        end else begin
            unique case (r_cmd)
                bpsm_pkg::CMD_PROD_ACQ, bpsm_pkg::CMD_OUT_ACQ: begin
                    if (r_free_f) begin
                        a_grant = 1'b1;
                        a_gidx  = r_free_i;
                    end else begin
                        a_ovr = 1'b1;
                        if (r_cmd == bpsm_pkg::CMD_PROD_ACQ) begin
                            a_drop = 1'b1;
                            if (i_cfg.drop_oldest && r_old_f) begin
                                // free the oldest ready block and hand it out
                                a_grant = 1'b1;
                                a_gidx  = r_old_i;
                                a_rdy   = r_rdy_cnt - CW'(1);
                            end else begin
                                a_st = bpsm_pkg::ST_OVERFLOW;
                            end
                        end else begin
                            a_st = bpsm_pkg::ST_OVERFLOW;
                        end
                    end
                    if (a_grant) begin
                        a_ph_we    = 1'b1;
                        a_ph_addr  = a_gidx;
                        a_ph_val   = bpsm_pkg::PH_PROD;
                        a_mem_we   = 1'b1;
                        a_stamp_we = 1'b1;
                    end
                end
                bpsm_pkg::CMD_PROD_COMMIT, bpsm_pkg::CMD_OUT_COMMIT: begin
                    if (idx_out || r_idx_ph != bpsm_pkg::PH_PROD
                            || r_vb > i_cfg.block_size_bytes) begin
                        a_corr = 1'b1;
                        a_st   = bpsm_pkg::ST_INVALID;
                    end else begin
                        a_ph_we     = 1'b1;
                        a_mem_we    = 1'b1;
                        a_vb_val    = r_vb;
                        a_stamp_we  = r_has_stamp;
                        a_stamp_val = r_stamp;
                        if (r_cmd == bpsm_pkg::CMD_PROD_COMMIT) begin
                            a_ph_val = bpsm_pkg::PH_READY;
                            a_seq_we = 1'b1;
                            a_rdy    = r_rdy_cnt + CW'(1);
                        end else begin
                            a_ph_val = bpsm_pkg::PH_OUTRDY;
                        end
                    end
                end
                bpsm_pkg::CMD_PROD_ABORT: begin
                    if (idx_out || r_idx_ph != bpsm_pkg::PH_PROD) begin
                        a_corr = 1'b1;
                        a_st   = bpsm_pkg::ST_INVALID;
                    end else begin
                        a_ph_we    = 1'b1;
                        a_mem_we   = 1'b1;
                        a_stamp_we = 1'b1;
                    end
                end
                bpsm_pkg::CMD_CONS_REL: begin
                    if (idx_out || (r_idx_ph != bpsm_pkg::PH_PROC
                            && r_idx_ph != bpsm_pkg::PH_OUTRDY)) begin
                        a_corr = 1'b1;
                        a_st   = bpsm_pkg::ST_INVALID;
                    end else begin
                        a_ph_we    = 1'b1;
                        a_mem_we   = 1'b1;
                        a_stamp_we = 1'b1;
                    end
                end
                bpsm_pkg::CMD_CONS_ACQ: begin
                    if (!r_old_f) begin
                        a_undr = 1'b1;
                        a_st   = bpsm_pkg::ST_BLOCK;
                    end else begin
                        a_ph_we   = 1'b1;
                        a_ph_addr = r_old_i;
                        a_ph_val  = bpsm_pkg::PH_PROC;
                        a_grant   = 1'b1;
                        a_cons    = 1'b1;
                        a_gidx    = r_old_i;
                        a_rdy     = r_rdy_cnt - CW'(1);
                    end
                end
                bpsm_pkg::CMD_LATE: a_late = 1'b1;
                default: ;
            endcase
        end
    end

    // Memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_ctl.apply && a_seq_we) seq_mem[r_idx] <= a_seq_next;
        r_sq_q <= seq_mem[r_scan_i[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.apply && a_mem_we) vb_mem[a_ph_addr] <= a_vb_val;
        r_vb_q <= vb_mem[r_old_i];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.apply && a_stamp_we) stamp_mem[a_ph_addr] <= a_stamp_val;
        r_st_q <= stamp_mem[r_old_i];
    end

    // Phases, counters and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_phase[k] <= bpsm_pkg::PH_FREE;
            r_seq_ctr <= '0;
            r_ovr     <= '0;
            r_drop    <= '0;
            r_corr    <= '0;
            r_undr    <= '0;
            r_late    <= '0;
            r_scan_i  <= '0;
            r_ev_v    <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_ev_v <= i_ctl.scan && (r_scan_i < pool_n);
            if (i_ctl.take) begin
                r_scan_i <= '0;
            end else if (i_ctl.scan && r_scan_i < pool_n) begin
                r_scan_i <= r_scan_i + CW'(1);
            end
            if (i_ctl.apply) begin
                if (a_clear) begin
                    for (int k = 0; k < N; k++) r_phase[k] <= bpsm_pkg::PH_FREE;
                    r_seq_ctr <= '0;
                    r_ovr     <= '0;
                    r_drop    <= '0;
                    r_corr    <= '0;
                    r_undr    <= '0;
                    r_late    <= '0;
                end else begin
                    if (a_ph_we) r_phase[a_ph_addr] <= a_ph_val;
                    if (a_seq_we) r_seq_ctr <= a_seq_next;
                    if (a_ovr)  r_ovr  <= r_ovr + WW'(1);
                    if (a_drop) r_drop <= r_drop + WW'(1);
                    if (a_corr) r_corr <= r_corr + WW'(1);
                    if (a_undr) r_undr <= r_undr + WW'(1);
                    if (a_late) r_late <= r_late + WW'(1);
                end
            end
            if (i_ctl.load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Scan evaluation and step payload
    always_ff @(posedge i_clk) begin
        r_ph_q <= r_phase[r_scan_i[IW-1:0]];
        r_ev_i <= r_scan_i[IW-1:0];
        if (i_ctl.take) begin
            r_cmd       <= i_command;
            r_idx       <= i_block_index;
            r_vb        <= i_valid_bytes;
            r_has_stamp <= i_stamp_present;
            r_stamp     <= i_stamp_in;
            r_free_f    <= 1'b0;
            r_old_f     <= 1'b0;
            r_rdy_cnt   <= '0;
            r_idx_ph    <= bpsm_pkg::PH_FREE;
        end else if (r_ev_v) begin
            if (r_ph_q == bpsm_pkg::PH_FREE && !r_free_f) begin
                r_free_f <= 1'b1;
                r_free_i <= r_ev_i;
            end
            if (r_ph_q == bpsm_pkg::PH_READY) begin
                r_rdy_cnt <= r_rdy_cnt + CW'(1);
                // keep the block whose sequence is older, wrap-safe
                if (!r_old_f || (r_sq_q - r_old_seq) >= WW'(1) << (WW - 1)) begin
                    r_old_f   <= 1'b1;
                    r_old_i   <= r_ev_i;
                    r_old_seq <= r_sq_q;
                end
            end
            if (r_ev_i == r_idx) r_idx_ph <= r_ph_q;
        end
        if (i_ctl.apply) begin
            r_res_st  <= a_st;
            r_grant   <= a_grant;
            r_cons_ok <= a_cons;
            r_res_idx <= a_gidx;
            r_res_rdy <= a_rdy;
        end
        if (i_ctl.fetch) begin
            r_res_addr  <= r_grant ? i_cfg.payload_base + WW'(addr_prod) : '0;
            r_res_held  <= r_cons_ok ? r_vb_q : '0;
            r_res_seq   <= r_cons_ok ? r_old_seq : '0;
            r_res_stamp <= r_cons_ok ? r_st_q : '0;
        end
        if (i_ctl.load) begin
            o_status          <= r_res_st;
            o_granted_index   <= r_res_idx;
            o_payload_address <= r_res_addr;
            o_held_bytes      <= r_res_held;
            o_sequence_out    <= r_res_seq;
            o_stamp_out       <= r_res_stamp;
            o_ready_count     <= r_res_rdy;
            o_overrun_count   <= r_ovr;
            o_drop_count      <= r_drop;
            o_corrupt_count   <= r_corr;
            o_underrun_count  <= r_undr;
            o_late_count      <= r_late;
        end
    end

    assign o_out_valid = r_out_v;

endmodule

### rtl/block_pool_stream_manager_core.sv
// Top level: configuration registers, sequencer and datapath of the block pool manager.
//
//  channel   direction  handshake          payload
//  command   in         i_valid / o_ready  i_command .. i_stamp_in
//  result    out        o_valid / i_ready  o_status .. o_late_count
//  config    in         APB psel/penable   paddr, pwdata, prdata
//
// For each transaction, one pass over the active descriptors finds the
// lowest free block, the oldest ready block and the ready count; then the apply
// state applies the command, the fetch state reads payload data and forms the
// address, and the done state loads the result. A new command is taken once
// the previous one is loaded. A stalled result holds its register and blocks
// only the load of the following one. Reset is synchronous and frees every block
// and clears every counter.
module block_pool_stream_manager_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bpsm_pkg::ADDR_W-1:0]          paddr,
    input  logic [bpsm_pkg::WORD_W-1:0]          pwdata,
    output logic [bpsm_pkg::WORD_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [3:0]                           i_command,
    input  logic [bpsm_pkg::IDX_W-1:0]           i_block_index,
    input  logic [bpsm_pkg::BYTES_W-1:0]         i_valid_bytes,
    input  logic                                 i_stamp_present,
    input  logic [bpsm_pkg::STAMP_W-1:0]         i_stamp_in,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [1:0]                           o_status,
    output logic [bpsm_pkg::IDX_W-1:0]           o_granted_index,
    output logic [bpsm_pkg::WORD_W-1:0]          o_payload_address,
    output logic [bpsm_pkg::BYTES_W-1:0]         o_held_bytes,
    output logic [bpsm_pkg::WORD_W-1:0]          o_sequence_out,
    output logic [bpsm_pkg::STAMP_W-1:0]         o_stamp_out,
    output logic [bpsm_pkg::CNT_W-1:0]           o_ready_count,
    output logic [bpsm_pkg::WORD_W-1:0]          o_overrun_count,
    output logic [bpsm_pkg::WORD_W-1:0]          o_drop_count,
    output logic [bpsm_pkg::WORD_W-1:0]          o_corrupt_count,
    output logic [bpsm_pkg::WORD_W-1:0]          o_underrun_count,
    output logic [bpsm_pkg::WORD_W-1:0]          o_late_count
);

    bpsm_pkg::t_cfg r_cfg;
    bpsm_pkg::t_ctl ctl;
    bpsm_pkg::t_sts sts;
    bpsm_pkg::t_reg_idx reg_sel;
    logic cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = bpsm_pkg::t_reg_idx'(paddr[bpsm_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_blocks    <= bpsm_pkg::CNT_W'(bpsm_pkg::MAX_BLOCKS);
            r_cfg.block_size_bytes <= bpsm_pkg::BYTES_W'(1024);
            r_cfg.drop_oldest      <= 1'b0;
            r_cfg.payload_base     <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                bpsm_pkg::REG_ACTIVE: r_cfg.active_blocks <= pwdata[bpsm_pkg::CNT_W-1:0];
                bpsm_pkg::REG_SIZE:   r_cfg.block_size_bytes <= pwdata[bpsm_pkg::BYTES_W-1:0];
                bpsm_pkg::REG_DROP:   r_cfg.drop_oldest <= pwdata[0];
                bpsm_pkg::REG_BASE:   r_cfg.payload_base <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            bpsm_pkg::REG_ACTIVE: prdata = bpsm_pkg::WORD_W'(r_cfg.active_blocks);
            bpsm_pkg::REG_SIZE:   prdata = bpsm_pkg::WORD_W'(r_cfg.block_size_bytes);
            bpsm_pkg::REG_DROP:   prdata = bpsm_pkg::WORD_W'(r_cfg.drop_oldest);
            bpsm_pkg::REG_BASE:   prdata = r_cfg.payload_base;
            default:              prdata = '0;
        endcase
    end

    bpsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    bpsm_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_ctl             (ctl),
        .o_sts             (sts),
        .i_command         (i_command),
        .i_block_index     (i_block_index),
        .i_valid_bytes     (i_valid_bytes),
        .i_stamp_present   (i_stamp_present),
        .i_stamp_in        (i_stamp_in),
        .i_out_ready       (i_ready),
        .o_out_valid       (o_valid),
        .o_status          (o_status),
        .o_granted_index   (o_granted_index),
        .o_payload_address (o_payload_address),
        .o_held_bytes      (o_held_bytes),
        .o_sequence_out    (o_sequence_out),
        .o_stamp_out       (o_stamp_out),
        .o_ready_count     (o_ready_count),
        .o_overrun_count   (o_overrun_count),
        .o_drop_count      (o_drop_count),
        .o_corrupt_count   (o_corrupt_count),
        .o_underrun_count  (o_underrun_count),
        .o_late_count      (o_late_count)
    );

endmodule
